// ===== hdl/http_upgrade_header_stripper_unit_defines.svh =====
// Assertion macros used by the upgrade header stripper RTL.
`ifndef HTTP_UPGRADE_HEADER_STRIPPER_UNIT_DEFINES_SVH
`define HTTP_UPGRADE_HEADER_STRIPPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define HUS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define HUS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hus_pkg.sv =====
// Types, constants and parse-step functions of the upgrade header stripper.
`default_nettype none

package hus_pkg;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SKIP,
    PH_NAME,
    PH_VALUE,
    PH_PASS,
    PH_REJECT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [3:0] NameLen   = 4'd8;
  localparam logic [3:0] ValueLen  = 4'd9;
  localparam logic [1:0] MethodLen = 2'd3;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] line_pos;
    logic       name_match;
    logic [3:0] value_idx;
    logic       value_ok;
    logic       up_acc;
    logic       cr_pending;
  } state_t;

  typedef struct packed {
    state_t     st;
    logic       emit;
    kind_e      kind;
    logic [7:0] data;
  } step_t;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] method_char(logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h47;  // G
      2'd1:    ch = 8'h45;  // E
      2'd2:    ch = 8'h54;  // T
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] name_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h55;  // U
      3'd1:    ch = 8'h50;  // P
      3'd2:    ch = 8'h47;  // G
      3'd3:    ch = 8'h52;  // R
      3'd4:    ch = 8'h41;  // A
      3'd5:    ch = 8'h44;  // D
      3'd6:    ch = 8'h45;  // E
      3'd7:    ch = 8'h3a;  // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] value_char(logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h77;  // w
      4'd1:    ch = 8'h65;  // e
      4'd2:    ch = 8'h62;  // b
      4'd3:    ch = 8'h73;  // s
      4'd4:    ch = 8'h6f;  // o
      4'd5:    ch = 8'h63;  // c
      4'd6:    ch = 8'h6b;  // k
      4'd7:    ch = 8'h65;  // e
      4'd8:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic step_t quiet(state_t s);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.kind = KIND_PAYLOAD;
    r.data = 8'h00;
    return r;
  endfunction

  function automatic step_t reject(state_t s);
    step_t r;
    r = quiet(s);
    r.st.phase      = PH_REJECT;
    r.st.value_ok   = 1'b0;
    r.st.cr_pending = 1'b0;
    r.emit          = 1'b1;
    r.kind          = KIND_REJECT;
    return r;
  endfunction

  // One character that does not end a line, in the skip, name or value phase.
  function automatic step_t ordinary(state_t s, logic [7:0] c);
    step_t r;
    logic  to_value;
    r        = quiet(s);
    to_value = 1'b0;
    case (s.phase)
      PH_NAME: begin
        if (s.up_acc || !s.name_match) begin
          r.st.phase = PH_SKIP;
        end else if (s.line_pos < NameLen) begin
          if (upcase(c) != name_char(s.line_pos[2:0])) begin
            r.st.name_match = 1'b0;
            r.st.phase      = PH_SKIP;
          end else begin
            r.st.line_pos = s.line_pos + 4'd1;
          end
        end else begin
          // The full name has matched; this character is the first of the value.
          r.st.phase     = PH_VALUE;
          r.st.value_idx = 4'd0;
          r.st.value_ok  = 1'b1;
          to_value       = 1'b1;
        end
      end
      PH_VALUE: to_value = 1'b1;
      default: ;
    endcase
    if (to_value) begin
      if (r.st.value_idx == 4'd0 && (c == CharSpace || c == CharTab)) begin
        r.st.value_idx = 4'd0;
      end else if (r.st.value_idx < ValueLen && c == value_char(r.st.value_idx)) begin
        r.st.value_idx = r.st.value_idx + 4'd1;
      end else begin
        r = reject(r.st);
      end
    end
    return r;
  endfunction

  function automatic step_t line_end(state_t s);
    step_t r;
    r = quiet(s);
    if (s.phase == PH_NAME && s.line_pos == 4'd0) begin
      if (!s.up_acc) begin
        r = reject(s);
      end else begin
        r.st.phase = PH_PASS;
        r.emit     = 1'b1;
        r.kind     = KIND_ACCEPT;
      end
    end else if (s.phase == PH_VALUE && (s.value_idx == 4'd0 || !s.value_ok)) begin
      r = reject(s);
    end else begin
      if (s.phase == PH_VALUE) begin
        r.st.up_acc = 1'b1;
      end
      r.st.phase      = PH_NAME;
      r.st.line_pos   = 4'd0;
      r.st.name_match = 1'b1;
    end
    return r;
  endfunction

  // Full processing of one stream byte.
  function automatic step_t parse_byte(state_t s, logic [7:0] c);
    step_t r;
    step_t cr;
    r  = quiet(s);
    cr = quiet(s);
    case (s.phase)
      PH_PASS: begin
        r.emit = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.data = c;
      end
      PH_METHOD: begin
        if (s.line_pos > 4'd2 || upcase(c) != method_char(s.line_pos[1:0])) begin
          r = reject(s);
        end else if (s.line_pos[1:0] + 2'd1 == MethodLen) begin
          r.st.phase    = PH_SKIP;
          r.st.line_pos = 4'd0;
        end else begin
          r.st.line_pos = s.line_pos + 4'd1;
        end
      end
      PH_SKIP, PH_NAME, PH_VALUE: begin
        r.st.cr_pending = 1'b0;
        if (s.cr_pending && c == CharLf) begin
          r = line_end(r.st);
        end else begin
          // A held CR that is not followed by LF counts as an ordinary character.
          if (s.cr_pending) begin
            cr = ordinary(r.st, CharCr);
            r  = cr;
          end
          if (!cr.emit) begin
            if (c == CharCr) begin
              r.st.cr_pending = 1'b1;
            end else begin
              r = ordinary(r.st, c);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/http_upgrade_header_stripper_unit.sv =====
// Top level of the upgrade header stripper: input stage, parse step, result register.
// Checks that a connection opens with a GET request whose first Upgrade header carries
// a prefix of "websocket". Header bytes are consumed; at the blank line ending the
// header one accept transaction (tuser = 1) is sent and every later byte is forwarded
// as a payload transaction (tuser = 0). A failed check sends one reject transaction
// (tuser = 2) and all further bytes are swallowed until reset. One byte is taken per
// clock with no bubbles while the result register is not stalled; a byte enters an input
// register, is parsed combinationally against the parser state and lands in the result
// register. A stalled result register holds one byte in the input register and then
// stops taking bytes. Bytes that produce no result leave no transaction.
`default_nettype none

`include "http_upgrade_header_stripper_unit_defines.svh"

module http_upgrade_header_stripper_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] stream_byte
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output      logic [1:0] m_axis_tuser    // [1:0] result_kind
);
  import hus_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  state_t     st_q, st_d;
  step_t      step;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  kind_e      out_kind_q, out_kind_d;

  // The parse step runs when a byte is buffered and the result register is free or is being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Next parser state.
  always_comb begin
    step = parse_byte(st_q, in_byte_q);
    st_d = advance ? step.st : st_q;
  end

  // Next result register contents.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    if (advance && step.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = step.data;
      out_kind_d  = step.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_METHOD;
      st_q.line_pos   <= 4'd0;
      st_q.name_match <= 1'b0;
      st_q.value_idx  <= 4'd0;
      st_q.value_ok   <= 1'b0;
      st_q.up_acc     <= 1'b0;
      st_q.cr_pending <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  `HUS_ASSERT_NOW(a_no_result_after_reject, advance && st_q.phase == PH_REJECT, !step.emit,
                  "parser produced a result after rejecting the header")
  `HUS_ASSERT_NOW(a_accept_enters_pass, advance && step.emit && step.kind == KIND_ACCEPT,
                  step.st.phase == PH_PASS, "accept result without entering pass-through")
  `HUS_ASSERT_NOW(a_status_has_zero_data, out_valid_q && out_kind_q != KIND_PAYLOAD,
                  out_data_q == 8'h00, "status result carries nonzero data")
  `HUS_ASSERT_NEXT(a_input_stage_holds, in_valid_q && !advance, in_valid_q,
                   "buffered byte lost while the result register was stalled")

endmodule

`default_nettype wire

// ===== tb/http_upgrade_header_stripper_unit_tb.sv =====
// Self-checking testbench for the HTTP upgrade header stripper stream unit.
`timescale 1ns / 1ps

module http_upgrade_header_stripper_unit_tb;
  import hus_pkg::*;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned HoldoffCycles = 120;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [23:0] MethodText = "GET";
  localparam logic [63:0] NameText   = "UPGRADE:";
  localparam logic [71:0] ValueText  = "websocket";

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  http_upgrade_header_stripper_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Parser state as the predictor tracks it.
  phase_e     hdr_phase;
  logic [3:0] hdr_pos;
  logic       name_hit;
  logic [3:0] val_idx;
  logic       val_ok;
  logic       upgrade_seen;
  logic       cr_held;

  result_t     awaited_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        no_gaps;
  logic        holdoff_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? {c[7:6], 1'b0, c[4:0]} : c;
  endfunction

  function automatic void push_result(input kind_e k, input logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data = d;
    awaited_results = {awaited_results, r};
  endfunction

  function automatic logic note_reject();
    hdr_phase = PH_REJECT;
    val_ok    = 1'b0;
    cr_held   = 1'b0;
    push_result(KIND_REJECT, 8'h00);
    return 1'b1;
  endfunction

  // A character that does not close a line; returns high when it caused a result.
  function automatic logic line_char(input logic [7:0] c);
    if (hdr_phase == PH_NAME) begin
      if (upgrade_seen || !name_hit) begin
        hdr_phase = PH_SKIP;
        return 1'b0;
      end
      if (hdr_pos < 4'd8) begin
        if (to_upper(c) != NameText[8*(7-int'(hdr_pos)) +: 8]) begin
          name_hit  = 1'b0;
          hdr_phase = PH_SKIP;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
        return 1'b0;
      end
      hdr_phase = PH_VALUE;
      val_idx   = 4'd0;
      val_ok    = 1'b1;
    end
    if (hdr_phase == PH_VALUE) begin
      if (val_idx == 4'd0 && (c == CharSpace || c == CharTab)) return 1'b0;
      if (val_idx < 4'd9 && c == ValueText[8*(8-int'(val_idx)) +: 8]) begin
        val_idx = val_idx + 4'd1;
        return 1'b0;
      end
      return note_reject();
    end
    return 1'b0;
  endfunction

  function automatic void line_done();
    if (hdr_phase == PH_NAME && hdr_pos == 4'd0) begin
      if (!upgrade_seen) begin
        void'(note_reject());
      end else begin
        hdr_phase = PH_PASS;
        push_result(KIND_ACCEPT, 8'h00);
      end
      return;
    end
    if (hdr_phase == PH_VALUE) begin
      if (val_idx == 4'd0 || !val_ok) begin
        void'(note_reject());
        return;
      end
      upgrade_seen = 1'b1;
    end
    hdr_phase = PH_NAME;
    hdr_pos   = 4'd0;
    name_hit  = 1'b1;
  endfunction

  // Advances the parser by one accepted byte and queues the result it causes.
  function automatic void predict_stripper_byte(input logic [7:0] c);
    case (hdr_phase)
      PH_PASS: push_result(KIND_PAYLOAD, c);
      PH_METHOD: begin
        if (hdr_pos > 4'd2 || to_upper(c) != MethodText[8*(2-int'(hdr_pos)) +: 8]) begin
          void'(note_reject());
        end else begin
          hdr_pos = hdr_pos + 4'd1;
          if (hdr_pos == 4'd3) begin
            hdr_phase = PH_SKIP;
            hdr_pos   = 4'd0;
          end
        end
      end
      PH_SKIP, PH_NAME, PH_VALUE: begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (c == CharLf) begin
            line_done();
            return;
          end
          // A CR without LF behind it is a plain line character.
          if (line_char(CharCr)) return;
        end
        if (c == CharCr) begin
          cr_held = 1'b1;
        end else begin
          void'(line_char(c));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] random_line_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharCr || c == CharLf);
    return c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (to_upper(c) >= "A" && to_upper(c) <= "Z" && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_stripper_byte(b);
  endtask

  task automatic send_text(input string s, input logic mixed);
    for (int i = 0; i < s.len(); i++) send_byte(mixed ? flip_case(s[i]) : s[i]);
  endtask

  // A header line whose name can never be taken for the Upgrade name.
  task automatic send_filler_line(input logic with_lone_cr);
    logic [7:0]  c;
    int unsigned n;
    do c = random_line_byte(); while (to_upper(c) == "U");
    send_byte(c);
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      if (with_lone_cr && i == n / 2) begin
        send_byte(CharCr);
        do c = random_line_byte(); while (c == CharCr);
        send_byte(c);
      end
      send_byte(random_line_byte());
    end
    send_text("\r\n", 1'b0);
  endtask

  task automatic test_request_line();
    send_text("GET", 1'b1);
    send_text(" /chat", 1'b0);
    // A lone CR inside the line, then a CR right before the terminating CRLF.
    send_byte(CharCr);
    send_byte("x");
    send_byte(random_line_byte());
    send_text(" HTTP/1.1\r\r\n", 1'b0);
  endtask

  task automatic test_header_lines();
    int unsigned n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_filler_line(1'($urandom_range(0, 1)));
    send_text("Upgradex: websocket\r\n", 1'b1);
    // A name with nothing after the colon does not count as the Upgrade line.
    send_text("Upgrade:\r\n", 1'b1);
    send_text("Upgrade:", 1'b1);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte($urandom_range(0, 1) ? CharSpace : CharTab);
    n = $urandom_range(1, 9);
    for (int i = 0; i < n; i++) send_byte(ValueText[8*(8-i) +: 8]);
    send_text("\r\n", 1'b0);
    // Later Upgrade lines are skipped, whatever they carry.
    send_text("Upgrade: h2c\r\n", 1'b1);
    send_filler_line(1'b1);
  endtask

  task automatic test_blank_line();
    send_text("\r\n", 1'b0);
  endtask

  task automatic test_payload_extremes();
    logic [7:0] pattern[12];
    pattern = '{8'h00, 8'hff, CharCr, CharLf, CharCr, CharLf, 8'h80, 8'h7f, 8'h55, 8'haa,
                "G", CharTab};
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  task automatic test_payload_random();
    for (int i = 0; i < 680; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_byte(8'($urandom_range(0, 255)));
    end
    no_gaps = 1'b0;
  endtask

  // The sink stops taking results while bytes keep coming back to back.
  task automatic test_receiver_holdoff();
    holdoff_req = 1'b1;
    no_gaps     = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)));
    no_gaps = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldoffCycles) @(negedge clk_i);
        holdoff_req = 1'b0;
      end
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected transaction: kind %0d data %02h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser != want.kind || m_axis_tdata != want.data) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("mismatch: expected kind %0d data %02h, got kind %0d data %02h",
                     want.kind, want.data, m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("http_upgrade_header_stripper_unit regression: fail");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    rst_ni         = 1'b0;
    no_gaps        = 1'b0;
    holdoff_req    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    hdr_phase      = PH_METHOD;
    hdr_pos        = 4'd0;
    name_hit       = 1'b0;
    val_idx        = 4'd0;
    val_ok         = 1'b0;
    upgrade_seen   = 1'b0;
    cr_held        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_request_line();
    test_header_lines();
    test_blank_line();
    test_payload_extremes();
    test_payload_random();
    test_receiver_holdoff();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("http_upgrade_header_stripper_unit regression: pass");
    end else begin
      $display("http_upgrade_header_stripper_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== http_upgrade_header_stripper_unit.f =====
+incdir+hdl
hdl/hus_pkg.sv
hdl/http_upgrade_header_stripper_unit.sv
tb/http_upgrade_header_stripper_unit_tb.sv
